// ===== sv/i2c_clock_divider_search_assert.svh =====
// assertion macros for the divider search checker
// needs clk and arst_n in the scope where a macro is used
`ifndef I2C_CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define I2C_CLOCK_DIVIDER_SEARCH_ASSERT_SVH

// condition in the same cycle implies consequence in the same cycle
`define I2CCDS_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence a fixed number of cycles later
`define I2CCDS_ASSERT_LATER(label, cond, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== sv/i2ccds_pkg.sv =====
// shared types and constants of the i2c clock divider search
// no dependencies
`timescale 1ns / 1ps

package i2ccds_pkg;

	localparam int          M_COUNT    = 16;
	localparam int          N_COUNT    = 8;
	localparam int          S10_W      = 29;
	localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;
	localparam int          TEN_SHIFT  = 35;
	localparam logic [3:0]  FALLBACK_M = 4'd5;
	localparam logic [2:0]  FALLBACK_N = 3'd0;

	// beat travelling down the cell row
	typedef struct packed {
		logic              valid;
		logic [S10_W-1:0]  s10;
		logic [31:0]       want;
		logic              have;
		logic [31:0]       gap;
		logic [3:0]        m;
		logic [2:0]        n;
	} beat_t;

endpackage

// ===== sv/i2ccds_cell.sv =====
// one cell of the divider search row: handles one multiplier m for all n
// depends on i2ccds_pkg
`timescale 1ns / 1ps

module i2ccds_cell #(
	parameter int M_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2ccds_pkg::beat_t    beat_in,
	output i2ccds_pkg::beat_t    beat_out
);

	localparam int          DIV   = M_IDX + 1;
	localparam int          L     = $clog2(DIV);
	localparam int          SH    = i2ccds_pkg::S10_W + L;
	localparam logic [63:0] MAG64 = (64'd1 << SH) / DIV + 64'd1;
	localparam logic [30:0] MAGIC = MAG64[30:0];
	localparam logic [3:0]  MY_M  = 4'(M_IDX);

	i2ccds_pkg::beat_t beat_s1;
	logic [59:0]       prod_s1;
	i2ccds_pkg::beat_t beat_s2;

	logic [59:0]       prod_c;
	logic [28:0]       quot;
	logic              fit;
	logic [2:0]        fit_n;
	logic [31:0]       fit_f;
	logic [31:0]       fit_gap;
	logic              take;
	logic [31:0]       f_n;

	assign prod_c = 60'(beat_in.s10) * 60'(MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else begin
			beat_s1 <= beat_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

	assign quot = 29'(prod_s1 >> SH);

	// first n whose frequency fits under the wanted rate
	always_comb begin
		fit   = 1'b0;
		fit_n = '0;
		fit_f = '0;
		f_n   = '0;
		for (int i = i2ccds_pkg::N_COUNT - 1; i >= 0; i--) begin
			f_n = 32'(quot >> i);
			if (f_n <= beat_s1.want) begin
				fit   = 1'b1;
				fit_n = 3'(i);
				fit_f = f_n;
			end
		end
	end

	assign fit_gap = beat_s1.want - fit_f;
	assign take = fit && (!beat_s1.have || (fit_gap < beat_s1.gap) ||
		((fit_gap == beat_s1.gap) && (fit_n < beat_s1.n)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s2 <= '0;
		end else begin
			beat_s2.valid <= beat_s1.valid;
			beat_s2.s10   <= beat_s1.s10;
			beat_s2.want  <= beat_s1.want;
			if (take) begin
				beat_s2.have <= 1'b1;
				beat_s2.gap  <= fit_gap;
				beat_s2.m    <= MY_M;
				beat_s2.n    <= fit_n;
			end else begin
				beat_s2.have <= beat_s1.have;
				beat_s2.gap  <= beat_s1.gap;
				beat_s2.m    <= beat_s1.m;
				beat_s2.n    <= beat_s1.n;
			end
		end
	end

	assign beat_out = beat_s2;

endmodule

// ===== sv/i2c_clock_divider_search.sv =====
// top level of the i2c clock divider search: front divide by ten and a row of 16 cells
// depends on i2ccds_pkg and i2ccds_cell
`timescale 1ns / 1ps

// channel  | ports                                  | handshake
// ---------+----------------------------------------+-----------------------------
// input    | source_clock_hz, wanted_rate_hz        | start high while busy low
// result   | divider_m, divider_n                   | done strobe, one cycle
//
// one beat accepted every cycle; busy is tied low
// the pipeline is one front stage, two stages in each of the 16 cells and one output
// register; the per-cell multiply by a reciprocal sets the depth
// reset clears the stage beats and the done strobe, not the products or result fields
// the receiver cannot stall, so beats never back up

module i2c_clock_divider_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] source_clock_hz,
	input  logic [31:0] wanted_rate_hz,
	output logic        done,
	output logic [3:0]  divider_m,
	output logic [2:0]  divider_n
);

	localparam int MC = i2ccds_pkg::M_COUNT;

	// front stage: source over ten, by reciprocal multiply
	logic [63:0]       ten_prod;
	i2ccds_pkg::beat_t front_s1;
	// row links, one more than cells
	i2ccds_pkg::beat_t link [MC+1];
	logic              done_q;
	logic [3:0]        m_q;
	logic [2:0]        n_q;

	// pipelined row never blocks intake
	assign busy = 1'b0;

	assign ten_prod = 64'(source_clock_hz) * 64'(i2ccds_pkg::RECIP_TEN);

	// search starts with no candidate held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else begin
			front_s1.valid <= start && !busy;
			front_s1.s10   <= ten_prod[i2ccds_pkg::TEN_SHIFT +: i2ccds_pkg::S10_W];
			front_s1.want  <= wanted_rate_hz;
			front_s1.have  <= 1'b0;
			front_s1.gap   <= '0;
			front_s1.m     <= i2ccds_pkg::FALLBACK_M;
			front_s1.n     <= i2ccds_pkg::FALLBACK_N;
		end
	end

	assign link[0] = front_s1;

	// cell k tries multiplier k over every exponent and keeps the better pick
	for (genvar k = 0; k < MC; k++) begin : g_cell
		i2ccds_cell #(
			.M_IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.beat_in  (link[k]),
			.beat_out (link[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= link[MC].valid;
		end
	end

	// found pair, or the fallback pair when nothing fit
	always_ff @(posedge clk) begin
		if (link[MC].have) begin
			m_q <= link[MC].m;
			n_q <= link[MC].n;
		end else begin
			m_q <= i2ccds_pkg::FALLBACK_M;
			n_q <= i2ccds_pkg::FALLBACK_N;
		end
	end

	assign done      = done_q;
	assign divider_m = m_q;
	assign divider_n = n_q;

endmodule

// ===== sv/i2ccds_checker.sv =====
// port level checks of the i2c clock divider search, bound to the top level
// depends on i2c_clock_divider_search_assert.svh
`timescale 1ns / 1ps
`include "i2c_clock_divider_search_assert.svh"

module i2ccds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] source_clock_hz,
	input logic        done,
	input logic [3:0]  divider_m,
	input logic [2:0]  divider_n
);

	`I2CCDS_ASSERT_LATER(a_beat_done, start && !busy, 34, done, "accepted beat gave no result")
	`I2CCDS_ASSERT_NOW(a_done_src, done, $past(start && !busy, 34), "result without a beat")
	`I2CCDS_ASSERT_NOW(a_zero_src, done && ($past(source_clock_hz, 34) == 32'd0),
		(divider_m == 4'd0) && (divider_n == 3'd0), "zero source clock must pick first pair")

endmodule

bind i2c_clock_divider_search i2ccds_checker u_i2ccds_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.source_clock_hz (source_clock_hz),
	.done            (done),
	.divider_m       (divider_m),
	.divider_n       (divider_n)
);
